>>> sv/lla_pkg.sv
// ----------------------------------------------------------------------------
// lla_pkg - shared types and constants for the life-like automaton block
// Holds default board geometry, port widths, rule register codes and the
// control bundle that steers each row cell.
// ----------------------------------------------------------------------------
package lla_pkg;

  // Default board geometry
  localparam int BOARD_ROWS_DEF = 32;
  localparam int BOARD_COLS_DEF = 32;

  // Fixed port widths
  localparam int ROW_IDX_W   = 5;
  localparam int COL_IDX_W   = 5;
  localparam int ROW_CELLS_W = 32;
  localparam int CNT_W       = 4;
  localparam int CFG_IDX_W   = 3;

  // Request codes
  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // Rule register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIRTH    = 3'd0,
    CFG_OVERPOP  = 3'd1,
    CFG_UNDERPOP = 3'd2,
    CFG_SURV_A   = 3'd3,
    CFG_SURV_B   = 3'd4
  } cfg_idx_t;

  // Rule registers as seen by the row calculator
  typedef struct packed {
    logic [CNT_W-1:0] birth;
    logic [CNT_W-1:0] overpop;
    logic [CNT_W-1:0] underpop;
    logic [CNT_W-1:0] surv_a;
    logic [CNT_W-1:0] surv_b;
  } rule_cfg_t;

  // Per-cell control bundle
  typedef struct packed {
    logic shift_en;
    logic wr_en;
    logic wr_alive;
  } cell_ctl_t;

endpackage

>>> sv/life_like_automaton_generation.sv
// ----------------------------------------------------------------------------
// life_like_automaton_generation - life-like cellular automaton engine
// Keeps a board of live/dead cells in a chain of row cells and sweeps one
// generation through a three-row window, emitting the new board row by row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): a write request (req_type 0) sets one cell and
//   completes in the transfer cycle with no result; out-of-board addresses
//   are dropped. An advance request (req_type 1) starts a generation.
//   Result channel (out_*): one transfer per board row, row 0 first,
//   last_row set on the final row.
//   Config channel (cfg_*): always ready; writes the five rule registers.
//   First row: the advance moves the sequencer into its generation state,
//   which then registers row 0 into the result register. Throughput: the
//   row chain shifts by one row per cycle while the receiver does not stall,
//   and the input channel stays busy until the final row is registered.
//   The block accepts a new request while the final row still waits.
//   Stall: when the receiver holds off, the chain and row counter freeze and
//   the pending row stays unchanged on the outputs.
//   Reset: synchronous, active low; clears the board to all dead and loads
//   the default rule (birth 3, overpop 4, underpop 1, survive 2 and 3).
// ----------------------------------------------------------------------------
module life_like_automaton_generation
  import lla_pkg::*;
#(
  parameter int BOARD_ROWS = BOARD_ROWS_DEF,
  parameter int BOARD_COLS = BOARD_COLS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_req_type,
  input  logic [ROW_IDX_W-1:0]   in_cell_row,
  input  logic [COL_IDX_W-1:0]   in_cell_col,
  input  logic                   in_cell_alive,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ROW_IDX_W-1:0]   out_row_index,
  output logic [ROW_CELLS_W-1:0] out_row_cells,
  output logic                   out_last_row,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CNT_W-1:0]       cfg_wdata
);

  localparam int CW = $clog2(BOARD_COLS);
  localparam int RW = $clog2(BOARD_ROWS);
  localparam int AW = 8;

  typedef enum logic {
    ST_IDLE,
    ST_GEN
  } state_t;

  state_t                 state_r;
  logic [RW-1:0]          row_cnt_r;
  logic [BOARD_COLS-1:0]  prev_r;
  logic                   out_valid_r;
  logic [ROW_IDX_W-1:0]   out_row_index_r;
  logic [ROW_CELLS_W-1:0] out_row_cells_r;
  logic                   out_last_row_r;
  rule_cfg_t              rule_r;

  logic                   in_xfer;
  logic                   wr_go;
  logic                   adv;
  logic                   at_last;
  logic [CW-1:0]          wr_col;
  logic [BOARD_COLS-1:0]  row_q   [BOARD_ROWS];
  logic [BOARD_COLS-1:0]  next_row;
  logic [BOARD_COLS-1:0]  new_row;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign wr_go     = in_xfer && (in_req_type == REQ_WRITE)
                     && (AW'(in_cell_col) < AW'(BOARD_COLS));
  assign wr_col    = CW'(in_cell_col);
  assign adv       = (state_r == ST_GEN) && (!out_valid_r || out_ready);
  assign at_last   = (row_cnt_r == RW'(BOARD_ROWS - 1));
  assign cfg_ready = 1'b1;

  // Row chain: cell 0 is the row under evaluation, new rows enter at the tail
  for (genvar i = 0; i < BOARD_ROWS; i++) begin : g_row
    localparam logic [AW-1:0] ROW_ID = AW'(i);
    cell_ctl_t             ctl;
    logic [BOARD_COLS-1:0] sh_in;

    assign ctl.shift_en = adv;
    assign ctl.wr_en    = wr_go && (AW'(in_cell_row) == ROW_ID);
    assign ctl.wr_alive = in_cell_alive;

    if (i == BOARD_ROWS - 1) begin : g_tail
      assign sh_in = new_row;
    end else begin : g_body
      assign sh_in = row_q[i+1];
    end

    lla_row_cell #(
      .BOARD_COLS (BOARD_COLS),
      .CW         (CW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_col   (wr_col),
      .shift_in (sh_in),
      .row_q    (row_q[i])
    );
  end

  // Row below the bottom edge is dead
  assign next_row = at_last ? '0 : row_q[1];

  lla_row_calc #(
    .BOARD_COLS (BOARD_COLS)
  ) u_calc (
    .rule     (rule_r),
    .prev_row (prev_r),
    .cur_row  (row_q[0]),
    .next_row (next_row),
    .new_row  (new_row)
  );

  // Sequencer: state, row counter and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (in_xfer && in_req_type == REQ_ADVANCE) begin
            state_r   <= ST_GEN;
            row_cnt_r <= '0;
          end
        end
        ST_GEN: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            row_cnt_r   <= row_cnt_r + RW'(1);
            if (at_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Window top row and result payload
  always_ff @(posedge clk) begin
    if (in_xfer && in_req_type == REQ_ADVANCE) begin
      prev_r <= '0;
    end else if (adv) begin
      prev_r <= row_q[0];
    end
    if (adv) begin
      out_row_index_r <= ROW_IDX_W'(row_cnt_r);
      out_row_cells_r <= ROW_CELLS_W'(new_row);
      out_last_row_r  <= at_last;
    end
  end

  // Rule registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r.birth    <= CNT_W'(3);
      rule_r.overpop  <= CNT_W'(4);
      rule_r.underpop <= CNT_W'(1);
      rule_r.surv_a   <= CNT_W'(2);
      rule_r.surv_b   <= CNT_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BIRTH:    rule_r.birth    <= cfg_wdata;
        CFG_OVERPOP:  rule_r.overpop  <= cfg_wdata;
        CFG_UNDERPOP: rule_r.underpop <= cfg_wdata;
        CFG_SURV_A:   rule_r.surv_a   <= cfg_wdata;
        CFG_SURV_B:   rule_r.surv_b   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_index_r;
  assign out_row_cells = out_row_cells_r;
  assign out_last_row  = out_last_row_r;

endmodule

>>> sv/lla_row_cell.sv
// ----------------------------------------------------------------------------
// lla_row_cell - one board row in the row chain
// Holds one row of cells; loads its neighbor's row on a shift and updates a
// single column on a cell write.
// ----------------------------------------------------------------------------
module lla_row_cell
  import lla_pkg::*;
#(
  parameter int BOARD_COLS = BOARD_COLS_DEF,
  parameter int CW         = $clog2(BOARD_COLS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctl_t             ctl,
  input  logic [CW-1:0]         wr_col,
  input  logic [BOARD_COLS-1:0] shift_in,
  output logic [BOARD_COLS-1:0] row_q
);

  logic [BOARD_COLS-1:0] row_r;

  // Hold the row; shift in from the neighbor or write one column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (ctl.shift_en) begin
      row_r <= shift_in;
    end else if (ctl.wr_en) begin
      row_r[wr_col] <= ctl.wr_alive;
    end
  end

  assign row_q = row_r;

endmodule

>>> sv/lla_row_calc.sv
// ----------------------------------------------------------------------------
// lla_row_calc - next-generation logic for one row
// Counts the eight neighbors of every column from a three-row window and
// applies the birth, survival and death rules.
// ----------------------------------------------------------------------------
module lla_row_calc
  import lla_pkg::*;
#(
  parameter int BOARD_COLS = BOARD_COLS_DEF
) (
  input  rule_cfg_t             rule,
  input  logic [BOARD_COLS-1:0] prev_row,
  input  logic [BOARD_COLS-1:0] cur_row,
  input  logic [BOARD_COLS-1:0] next_row,
  output logic [BOARD_COLS-1:0] new_row
);

  logic [BOARD_COLS+1:0] pp;
  logic [BOARD_COLS+1:0] pc;
  logic [BOARD_COLS+1:0] pn;
  logic [CNT_W-1:0]      nbr [BOARD_COLS];

  // Pad with dead cells beyond the left and right edges
  assign pp = {1'b0, prev_row, 1'b0};
  assign pc = {1'b0, cur_row,  1'b0};
  assign pn = {1'b0, next_row, 1'b0};

  // Count neighbors and apply the rule per column
  always_comb begin
    for (int c = 0; c < BOARD_COLS; c++) begin
      nbr[c] = CNT_W'(pp[c]) + CNT_W'(pp[c+1]) + CNT_W'(pp[c+2])
             + CNT_W'(pc[c])                   + CNT_W'(pc[c+2])
             + CNT_W'(pn[c]) + CNT_W'(pn[c+1]) + CNT_W'(pn[c+2]);
      if (!cur_row[c]) begin
        new_row[c] = (nbr[c] == rule.birth);
      end else if (nbr[c] >= rule.overpop) begin
        new_row[c] = 1'b0;
      end else if (nbr[c] == rule.surv_a || nbr[c] == rule.surv_b) begin
        new_row[c] = 1'b1;
      end else if (nbr[c] <= rule.underpop) begin
        new_row[c] = 1'b0;
      end else begin
        new_row[c] = 1'b1;
      end
    end
  end

endmodule

>>> sv/lla_checker.sv
// ----------------------------------------------------------------------------
// lla_checker - port-level checks for the life-like automaton block
// Watches the result and input channels for row ordering, stall behavior
// and reset.
// ----------------------------------------------------------------------------
module lla_checker
  import lla_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [ROW_IDX_W-1:0]   out_row_index,
  input logic [ROW_CELLS_W-1:0] out_row_cells,
  input logic                   out_last_row
);

  // Hold a stalled row unchanged
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index)
      && $stable(out_row_cells) && $stable(out_last_row))
    else $error("stalled result row changed");

  // Advance row index by one within a generation
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_row |=> out_valid
      && out_row_index == $past(out_row_index) + ROW_IDX_W'(1))
    else $error("result rows out of order");

  // Refuse requests while a generation is still being swept
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_row |-> !in_ready)
    else $error("request taken in the middle of a generation");

  // Drop any result at reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind life_like_automaton_generation lla_checker u_lla_checker (.*);
